// File: design/kbd_dec_pkg.sv
`timescale 1ns / 1ps
// kbd_dec_pkg: scan codes, command bytes, character roms and the queue interface structs
// for the keyboard scan code decoder; depends on nothing

package kbd_dec_pkg;

  // keyboard and command bytes
  localparam logic [7:0] LED_CMD     = 8'hed;
  localparam logic [7:0] ACK_CODE    = 8'hfa;
  localparam logic [7:0] RESEND_CODE = 8'hfe;
  localparam logic [7:0] MAKE_LSHIFT = 8'h2a;
  localparam logic [7:0] MAKE_RSHIFT = 8'h36;
  localparam logic [7:0] BRK_LSHIFT  = 8'haa;
  localparam logic [7:0] BRK_RSHIFT  = 8'hb6;
  localparam logic [7:0] MAKE_CAPS   = 8'h3a;
  localparam logic [7:0] MAKE_NUM    = 8'h45;
  localparam logic [7:0] MAKE_SCROLL = 8'h46;

  // ascii helpers
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5a;

  // led bit masks
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // set 1 make codes, japanese layout, no shift held
  localparam logic [7:0] PLAIN_ROM [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  // same codes with either shift held
  localparam logic [7:0] SHIFTED_ROM [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

  // command queue control, one action per cycle
  typedef struct packed {
    logic       restart;
    logic [2:0] restart_led;
    logic       push;
    logic [7:0] push_byte;
    logic       pop;
  } cmdq_ctrl_t;

  // command queue status
  typedef struct packed {
    logic       empty;
    logic       multi;
    logic       full;
    logic [7:0] head_byte;
  } cmdq_stat_t;

endpackage

// File: design/kbd_dec_cmd_queue.sv
`timescale 1ns / 1ps
// kbd_dec_cmd_queue: command byte fifo with registered head read and two preloaded entries
// depends on kbd_dec_pkg

module kbd_dec_cmd_queue #(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kbd_dec_pkg::cmdq_ctrl_t ctrl,
  output kbd_dec_pkg::cmdq_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [CW-1:0] cnt;
  logic [1:0]    preload;
  logic [2:0]    preload_led;
  logic          push_ok;
  logic          pop_ok;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  // a full queue drops the byte
  assign push_ok = ctrl.push && !ctrl.restart && (cnt != FULL_CNT);
  assign pop_ok  = ctrl.pop && !ctrl.restart && (cnt != '0);

  // preloaded entries leave first and do not move the memory head
  always_comb begin
    head_next = head;
    if (rst || ctrl.restart) begin
      head_next = '0;
    end else if (pop_ok && (preload == 2'd0)) begin
      head_next = wrap_inc(head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      head        <= '0;
      tail        <= '0;
      cnt         <= CW'(2);
      preload     <= 2'd2;
      preload_led <= rst ? 3'd0 : ctrl.restart_led;
    end else begin
      head <= head_next;
      if (push_ok) begin
        tail <= wrap_inc(tail);
      end
      if (pop_ok && (preload != 2'd0)) begin
        preload <= preload - 2'd1;
      end
      if (push_ok && !pop_ok) begin
        cnt <= cnt + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // head read with write bypass for an empty memory
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= ctrl.push_byte;
    end
    rd_data <= (push_ok && (tail == head_next)) ? ctrl.push_byte : mem[head_next];
  end

  always_comb begin
    stat.empty = (cnt == '0);
    stat.multi = (cnt > CW'(1));
    stat.full  = (cnt == FULL_CNT);
    case (preload)
      2'd2:    stat.head_byte = kbd_dec_pkg::LED_CMD;
      2'd1:    stat.head_byte = {5'd0, preload_led};
      default: stat.head_byte = rd_data;
    endcase
  end

endmodule

// File: design/keyboard_scancode_decoder.sv
`timescale 1ns / 1ps
// keyboard_scancode_decoder: set 1 scan code to ascii decoder with lock leds and
// keyboard command queue; depends on kbd_dec_pkg and kbd_dec_cmd_queue
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------------
//   in       | in        | in_valid / in_stall        | scan_code[7:0]
//   out      | out       | out_valid / out_stall      | result_kind, result_value, last_of_run
//   config   | in        | initial_leds_write         | initial_leds[2:0]
//
// an item passes the decode stage in its decode phase, preceded by a phase when a queued
// command leaves ahead of it and followed by a phase for a lock key (the queue memory
// takes one byte per cycle) and by a phase when a command leaves after it; a command
// sent ahead leaves a lock key with nothing to send after it
// each result passes through the single output register; a request waiting there
// holds the decode stage only when the stage has another result to hand over
// reset is synchronous; it clears shift and lock state and loads the queue with the
// led command and led value, with no clearing pass
// a stalled output keeps its request; input stall is high while the stage holds an
// item that is not finishing in this cycle

module keyboard_scancode_decoder #(
  parameter int CMD_QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] result_value,
  output logic       last_of_run,
  input  logic       initial_leds_write,
  input  logic [2:0] initial_leds
);

  // decode stage phases
  localparam logic [1:0] PH_FIRST = 2'd0;  // command ahead of the item, else decode
  localparam logic [1:0] PH_DEC   = 2'd1;  // decode after a command has left
  localparam logic [1:0] PH_LED   = 2'd2;  // second byte of a lock key command
  localparam logic [1:0] PH_LAST  = 2'd3;  // command after the item

  // decode stage registers
  logic       item_valid;
  logic [7:0] code;
  logic [1:0] ph;
  logic [1:0] ph_next;

  // keyboard state
  logic [1:0] shift_bits;
  logic [2:0] lock_leds;
  logic       pending;
  logic [7:0] pending_byte;

  // output register
  logic       out_kind;
  logic [7:0] out_value;
  logic       out_last;

  kbd_dec_pkg::cmdq_ctrl_t qc;
  kbd_dec_pkg::cmdq_stat_t qs;

  logic [7:0] ch_raw;
  logic [7:0] ch;
  logic       send_ok;
  logic       do_send1;
  logic       do_dec;
  logic       do_led;
  logic       do_last;
  logic       is_toggle;
  logic [2:0] toggle_mask;
  logic       emit;
  logic       emit_kind;
  logic [7:0] emit_value;
  logic       emit_last;
  logic       done;
  logic       out_free;
  logic       fire;
  logic       accept;

  kbd_dec_cmd_queue #(
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .ctrl (qc),
    .stat (qs)
  );

  // character lookup; letters come out lower case unless caps and shift differ
  always_comb begin
    ch_raw = 8'h00;
    if (!code[7]) begin
      ch_raw = (shift_bits != 2'b00) ? kbd_dec_pkg::SHIFTED_ROM[code[6:0]]
                                     : kbd_dec_pkg::PLAIN_ROM[code[6:0]];
    end
    ch = ch_raw;
    if ((ch_raw inside {[kbd_dec_pkg::UPPER_A:kbd_dec_pkg::UPPER_Z]}) &&
        (lock_leds[2] == (shift_bits != 2'b00))) begin
      ch = ch_raw + kbd_dec_pkg::CASE_OFFSET;
    end
  end

  // lock keys
  always_comb begin
    is_toggle   = 1'b1;
    toggle_mask = 3'b000;
    case (code)
      kbd_dec_pkg::MAKE_CAPS:   toggle_mask = kbd_dec_pkg::LED_CAPS;
      kbd_dec_pkg::MAKE_NUM:    toggle_mask = kbd_dec_pkg::LED_NUM;
      kbd_dec_pkg::MAKE_SCROLL: toggle_mask = kbd_dec_pkg::LED_SCROLL;
      default:                  is_toggle   = 1'b0;
    endcase
  end

  // one command in flight at a time
  assign send_ok  = !qs.empty && !pending;
  assign do_send1 = item_valid && (ph == PH_FIRST) && send_ok;
  assign do_dec   = item_valid && ((ph == PH_DEC) || ((ph == PH_FIRST) && !send_ok));
  assign do_led   = item_valid && (ph == PH_LED);
  assign do_last  = item_valid && (ph == PH_LAST);

  always_comb begin
    emit       = 1'b0;
    emit_kind  = kbd_dec_pkg::KIND_CHAR;
    emit_value = ch;
    emit_last  = 1'b1;
    done       = 1'b1;
    ph_next    = PH_FIRST;
    if (do_send1) begin
      // more follows on a character, a resend, or an ack that frees the next byte
      emit       = 1'b1;
      emit_kind  = kbd_dec_pkg::KIND_CMD;
      emit_value = qs.head_byte;
      emit_last  = !((ch != 8'h00) || (code == kbd_dec_pkg::RESEND_CODE) ||
                     ((code == kbd_dec_pkg::ACK_CODE) && qs.multi));
      done       = 1'b0;
      ph_next    = PH_DEC;
    end else if (do_dec) begin
      // a character or a resend is always the final result of its item
      if (ch != 8'h00) begin
        emit = 1'b1;
      end else if ((code == kbd_dec_pkg::RESEND_CODE) && pending) begin
        emit       = 1'b1;
        emit_kind  = kbd_dec_pkg::KIND_CMD;
        emit_value = pending_byte;
      end
      if (is_toggle) begin
        done    = 1'b0;
        ph_next = PH_LED;
      end else if ((code == kbd_dec_pkg::ACK_CODE) && !qs.empty) begin
        done    = 1'b0;
        ph_next = PH_LAST;
      end
    end else if (do_led) begin
      // the queue is never empty after this write
      if (!pending) begin
        done    = 1'b0;
        ph_next = PH_LAST;
      end
    end else if (do_last) begin
      if (send_ok) begin
        emit       = 1'b1;
        emit_kind  = kbd_dec_pkg::KIND_CMD;
        emit_value = qs.head_byte;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && (!emit || out_free);
  assign in_stall = item_valid && !(fire && done);
  assign accept   = in_valid && !in_stall;

  // queue requests
  always_comb begin
    qc.restart     = initial_leds_write;
    qc.restart_led = initial_leds;
    qc.push        = 1'b0;
    qc.push_byte   = kbd_dec_pkg::LED_CMD;
    qc.pop         = 1'b0;
    if (fire) begin
      if (do_send1 || (do_last && send_ok)) begin
        qc.pop = 1'b1;
      end
      if (do_dec && is_toggle) begin
        qc.push = 1'b1;
      end
      if (do_led) begin
        qc.push      = 1'b1;
        qc.push_byte = {5'd0, lock_leds};
      end
    end
  end

  // decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      ph         <= PH_FIRST;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (fire && done) begin
        item_valid <= 1'b0;
      end
      if (fire) begin
        ph <= done ? PH_FIRST : ph_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code <= scan_code;
    end
  end

  // keyboard state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits   <= 2'b00;
      lock_leds    <= 3'b000;
      pending      <= 1'b0;
      pending_byte <= 8'h00;
    end else if (initial_leds_write) begin
      lock_leds    <= initial_leds;
      pending      <= 1'b0;
      pending_byte <= 8'h00;
    end else if (fire) begin
      if (do_send1 || (do_last && send_ok)) begin
        pending      <= 1'b1;
        pending_byte <= qs.head_byte;
      end
      if (do_dec) begin
        case (code)
          kbd_dec_pkg::MAKE_LSHIFT: shift_bits <= shift_bits | 2'b01;
          kbd_dec_pkg::MAKE_RSHIFT: shift_bits <= shift_bits | 2'b10;
          kbd_dec_pkg::BRK_LSHIFT:  shift_bits <= shift_bits & 2'b10;
          kbd_dec_pkg::BRK_RSHIFT:  shift_bits <= shift_bits & 2'b01;
          kbd_dec_pkg::ACK_CODE:    pending    <= 1'b0;
          default: begin
            if (is_toggle) begin
              lock_leds <= lock_leds ^ toggle_mask;
            end
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_kind  <= emit_kind;
      out_value <= emit_value;
      out_last  <= emit_last;
    end
  end

  assign result_kind  = out_kind;
  assign result_value = out_value;
  assign last_of_run  = out_last;

  // a sent command is awaiting its ack on the next cycle
  a_pop_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (qc.pop && !initial_leds_write) |=> pending)
    else $error("command sent without pending mark");

  // nothing leaves an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    qc.pop |-> !qs.empty)
    else $error("pop from empty command queue");

  // later phases only while an item is held
  a_phase_has_item: assert property (@(posedge clk) disable iff (rst)
    (ph != PH_FIRST) |-> item_valid)
    else $error("decode phase without an item");

  // a character always closes its run
  a_char_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == kbd_dec_pkg::KIND_CHAR)) |-> out_last)
    else $error("character result not marked last");

endmodule

// File: test/kbd_dec_checker.sv
`timescale 1ns / 1ps
// kbd_dec_checker: watches the scan code, result and led setting ports of the keyboard
// scan code decoder, predicts every result and counts mismatches; depends on kbd_dec_pkg

module kbd_dec_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] scan_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       result_kind,
  input  logic [7:0] result_value,
  input  logic       last_of_run,
  input  logic       initial_leds_write,
  input  logic [2:0] initial_leds,
  output int         mismatches,
  output int         outstanding
);

  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_Z     = 8'h5a;
  localparam logic [7:0] LOWER_SHIFT = 8'h20;
  localparam int         MAX_REPORTS = 10;

  // set 1 make codes to characters, japanese layout
  localparam logic [7:0] PLAIN_CHARS [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_CHARS [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } kbd_result_t;

  logic [1:0]  shift_held;
  logic [2:0]  lock_state;
  logic [7:0]  led_cmd_fifo [$];
  logic        cmd_in_flight;
  logic [7:0]  cmd_sent_byte;
  kbd_result_t awaited_results [$];

  task automatic queue_cmd(input logic [7:0] cmd);
    // bytes that do not fit are dropped one by one
    if (led_cmd_fifo.size() < QUEUE_DEPTH) led_cmd_fifo.push_back(cmd);
  endtask

  task automatic restart_cmds(input logic [2:0] leds);
    lock_state = leds;
    led_cmd_fifo.delete();
    cmd_in_flight = 1'b0;
    cmd_sent_byte = 8'h00;
    queue_cmd(kbd_dec_pkg::LED_CMD);
    queue_cmd({5'd0, leds});
  endtask

  task automatic await_result(input logic kind, input logic [7:0] value);
    kbd_result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    awaited_results.push_back(r);
  endtask

  task automatic send_next_cmd();
    if (led_cmd_fifo.size() != 0 && !cmd_in_flight) begin
      cmd_sent_byte = led_cmd_fifo.pop_front();
      cmd_in_flight = 1'b1;
      await_result(kbd_dec_pkg::KIND_CMD, cmd_sent_byte);
    end
  endtask

  task automatic toggle_lock(input logic [2:0] mask);
    lock_state = lock_state ^ mask;
    queue_cmd(kbd_dec_pkg::LED_CMD);
    queue_cmd({5'd0, lock_state});
  endtask

  task automatic decode_scan_code(input logic [7:0] code);
    int          first_new;
    logic [7:0]  ch;
    kbd_result_t r;
    first_new = awaited_results.size();
    send_next_cmd();
    ch = 8'h00;
    if (!code[7]) ch = (shift_held == 2'b00) ? PLAIN_CHARS[code[6:0]] : SHIFTED_CHARS[code[6:0]];
    // upper case only when exactly one of caps lock and shift is on
    if (ch >= ASCII_A && ch <= ASCII_Z && (lock_state[2] == (shift_held != 2'b00)))
      ch = ch + LOWER_SHIFT;
    if (ch != 8'h00) await_result(kbd_dec_pkg::KIND_CHAR, ch);
    case (code)
      kbd_dec_pkg::MAKE_LSHIFT: shift_held[0] = 1'b1;
      kbd_dec_pkg::MAKE_RSHIFT: shift_held[1] = 1'b1;
      kbd_dec_pkg::BRK_LSHIFT:  shift_held[0] = 1'b0;
      kbd_dec_pkg::BRK_RSHIFT:  shift_held[1] = 1'b0;
      kbd_dec_pkg::MAKE_CAPS:   toggle_lock(kbd_dec_pkg::LED_CAPS);
      kbd_dec_pkg::MAKE_NUM:    toggle_lock(kbd_dec_pkg::LED_NUM);
      kbd_dec_pkg::MAKE_SCROLL: toggle_lock(kbd_dec_pkg::LED_SCROLL);
      kbd_dec_pkg::ACK_CODE:    cmd_in_flight = 1'b0;
      kbd_dec_pkg::RESEND_CODE:
        if (cmd_in_flight) await_result(kbd_dec_pkg::KIND_CMD, cmd_sent_byte);
      default: ;
    endcase
    send_next_cmd();
    if (awaited_results.size() > first_new) begin
      r = awaited_results.pop_back();
      r.last = 1'b1;
      awaited_results.push_back(r);
    end
  endtask

  // results are compared before the same edge's request is decoded
  always @(posedge clk) begin
    kbd_result_t want;
    if (rst) begin
      shift_held = 2'b00;
      restart_cmds(3'd0);
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result kind %0d value %02h last %0d", $time,
                     result_kind, result_value, last_of_run);
        end else begin
          want = awaited_results.pop_front();
          if (want.kind !== result_kind || want.value !== result_value ||
              want.last !== last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: expected kind %0d value %02h last %0d, ",
                        "got kind %0d value %02h last %0d"},
                       $time, want.kind, want.value, want.last,
                       result_kind, result_value, last_of_run);
          end
        end
      end
      if (initial_leds_write) restart_cmds(initial_leds);
      if (in_valid && !in_stall) decode_scan_code(scan_code);
    end
    outstanding = awaited_results.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: drives scan codes and lock led settings into the keyboard scan code decoder and
// gives the verdict; depends on kbd_dec_pkg, keyboard_scancode_decoder and kbd_dec_checker

module tb;

  localparam int         QUEUE_DEPTH     = 32;
  localparam int         IDLE_LIMIT      = 3000;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         SETTLE_CYCLES   = 12;
  localparam int         PHASE_ITEMS     = 64;
  localparam logic [7:0] BREAK_BIT       = 8'h80;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // opening requests: both ends of the code range, both shift keys, every lock key,
  // resend and ack with and without a byte in flight, one of the two yen/backslash keys (7d)
  localparam logic [7:0] OPENING [27] = '{
    8'h1e, kbd_dec_pkg::RESEND_CODE, kbd_dec_pkg::ACK_CODE, kbd_dec_pkg::ACK_CODE,
    kbd_dec_pkg::ACK_CODE, kbd_dec_pkg::RESEND_CODE,
    8'h00, 8'h7f, 8'h80, 8'hff,
    kbd_dec_pkg::MAKE_LSHIFT, 8'h1e, kbd_dec_pkg::MAKE_RSHIFT, kbd_dec_pkg::BRK_LSHIFT,
    8'h02, kbd_dec_pkg::BRK_RSHIFT,
    kbd_dec_pkg::MAKE_CAPS, 8'h1e, kbd_dec_pkg::MAKE_LSHIFT, 8'h1e,
    kbd_dec_pkg::BRK_LSHIFT, kbd_dec_pkg::MAKE_CAPS | BREAK_BIT,
    kbd_dec_pkg::ACK_CODE, kbd_dec_pkg::MAKE_NUM, kbd_dec_pkg::MAKE_SCROLL,
    kbd_dec_pkg::ACK_CODE, 8'h7d
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] scan_code = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       result_kind;
  logic [7:0] result_value;
  logic       last_of_run;
  logic       initial_leds_write = 1'b0;
  logic [2:0] initial_leds = 3'd0;

  int mismatches;
  int outstanding;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int phase_items  = 0;
  bit hold_off_req = 1'b0;

  keyboard_scancode_decoder #(
    .CMD_QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .scan_code         (scan_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .result_value      (result_value),
    .last_of_run       (last_of_run),
    .initial_leds_write(initial_leds_write),
    .initial_leds      (initial_leds)
  );

  // prediction and comparison live beside the block
  kbd_dec_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) result_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .scan_code         (scan_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .result_value      (result_value),
    .last_of_run       (last_of_run),
    .initial_leds_write(initial_leds_write),
    .initial_leds      (initial_leds),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: too long without any request moving on either channel means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall modes, each held for a random span, plus one long hold-off
  // on request so that the output register and the decode stage back up to the input
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          tick;
    bit          hold_off_done;
    mode          = STALL_NONE;
    mode_left     = 0;
    tick          = 0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  // one request: valid goes up at a falling edge, held with its code until accepted;
  // bursts of random length, each opened by a random gap (sometimes none)
  task automatic send_code(input logic [7:0] code);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    scan_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_items++;
  endtask

  // drop valid and wait until every predicted result is out, then let the block run on
  // in case the last request left work behind without a result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // new led setting while idle; reloads the command queue in the block
  task automatic set_leds(input logic [2:0] leds);
    initial_leds_write <= 1'b1;
    initial_leds       <= leds;
    @(negedge clk);
    initial_leds_write <= 1'b0;
  endtask

  function automatic logic [7:0] any_key();
    logic [7:0] k;
    case ($urandom_range(0, 9))
      0:       k = 8'h73;
      1:       k = 8'h7d;
      default: k = 8'($urandom_range(1, 8'h58));
    endcase
    return k;
  endfunction

  function automatic logic [7:0] lock_key();
    logic [7:0] k;
    case ($urandom_range(0, 2))
      0:       k = kbd_dec_pkg::MAKE_CAPS;
      1:       k = kbd_dec_pkg::MAKE_NUM;
      default: k = kbd_dec_pkg::MAKE_SCROLL;
    endcase
    return k;
  endfunction

  // key pressed and released
  task automatic type_keys(input int count);
    logic [7:0] k;
    repeat (count) begin
      k = any_key();
      send_code(k);
      send_code(k | BREAK_BIT);
    end
  endtask

  // what the keyboard says back to a command byte: mostly ack, sometimes resend
  task automatic answer_keyboard(input int count);
    repeat (count)
      send_code(($urandom_range(0, 4) == 0) ? kbd_dec_pkg::RESEND_CODE
                                            : kbd_dec_pkg::ACK_CODE);
  endtask

  // lock keys with no answer until the command queue overflows, then drain it
  task automatic lock_storm();
    repeat ($urandom_range(16, 20)) send_code(lock_key());
    answer_keyboard($urandom_range(36, 44));
  endtask

  task automatic random_phase(input int target);
    int         pick;
    logic [7:0] sh;
    logic [7:0] lk;
    logic [7:0] noise;
    phase_items = 0;
    while (phase_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        type_keys($urandom_range(1, 3));
      end else if (pick < 52) begin
        // shifted word, now and then released on the wrong side
        sh = $urandom_range(0, 1) ? kbd_dec_pkg::MAKE_RSHIFT : kbd_dec_pkg::MAKE_LSHIFT;
        send_code(sh);
        type_keys($urandom_range(1, 4));
        if ($urandom_range(0, 5) == 0)
          send_code((sh == kbd_dec_pkg::MAKE_LSHIFT) ? kbd_dec_pkg::BRK_RSHIFT
                                                     : kbd_dec_pkg::BRK_LSHIFT);
        else
          send_code(sh | BREAK_BIT);
      end else if (pick < 67) begin
        lk = lock_key();
        send_code(lk);
        send_code(lk | BREAK_BIT);
        answer_keyboard($urandom_range(1, 3));
      end else if (pick < 77) begin
        answer_keyboard($urandom_range(1, 4));
      end else if (pick < 80) begin
        lock_storm();
      end else begin
        // stray byte: any value at all
        noise = 8'($urandom_range(0, 255));
        send_code(noise);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed opening from the reset setting
    foreach (OPENING[i]) send_code(OPENING[i]);
    settle();

    // all leds on, starting with a queue overflow
    set_leds(3'd7);
    lock_storm();
    random_phase(PHASE_ITEMS);
    settle();

    // all leds off, opened by the long receiver hold-off
    hold_off_req = 1'b1;
    set_leds(3'd0);
    random_phase(PHASE_ITEMS);
    settle();

    set_leds(3'($urandom_range(1, 6)));
    random_phase(PHASE_ITEMS);
    settle();

    set_leds(3'($urandom_range(0, 7)));
    random_phase(PHASE_ITEMS);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
